// ===== src/dda_line_rasterizer_macros.svh =====
// Assertion macros for the DDA line rasterizer checker.
// Needs nothing else; included by the checker file.
`ifndef DDA_LINE_RASTERIZER_MACROS_SVH
`define DDA_LINE_RASTERIZER_MACROS_SVH

// Property checked at every rising edge outside reset.
`define DDA_ASSERT_DIS(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("%m: assertion failed");

// Property checked at every rising edge, reset included.
`define DDA_ASSERT_ALL(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("%m: assertion failed");

`endif

// ===== src/dda_pkg.sv =====
// Shared defaults and types of the DDA line rasterizer.
// Used by the divider and the top level; depends on nothing.
`default_nettype none

package dda_pkg;

   localparam int COORD_BITS_DEF = 6;
   localparam int FRAC_BITS_DEF  = 16;

   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

endpackage

`default_nettype wire

// ===== src/dda_divider.sv =====
// Restoring fixed-point divider, one quotient bit per cycle.
// Computes (numer << FRAC_BITS) / denom for numer <= denom; uses dda_pkg.
`default_nettype none

module dda_divider #(
   parameter int COORD_BITS = 6,
   parameter int FRAC_BITS  = 16
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   start,
   input  wire logic [COORD_BITS-1:0]  numer,
   input  wire logic [COORD_BITS-1:0]  denom,
   output dda_pkg::div_stat_type       stat,
   output logic      [FRAC_BITS:0]     quot
);
   import dda_pkg::*;

   localparam int CNT_W = $clog2(FRAC_BITS + 2);

   logic [COORD_BITS:0]   rem_ff, rem_in;
   logic [COORD_BITS-1:0] den_ff, den_in;
   logic [FRAC_BITS:0]    quot_ff, quot_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic                  fits;
   logic [COORD_BITS:0]   diff;

   always_comb begin
      fits    = rem_ff >= {1'b0, den_ff};
      diff    = fits ? rem_ff - {1'b0, den_ff} : rem_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      quot_in = quot_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = {1'b0, numer};
         den_in  = denom;
         quot_in = '0;
         cnt_in  = CNT_W'(FRAC_BITS + 1);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in  = {diff[COORD_BITS-1:0], 1'b0};
         quot_in = {quot_ff[FRAC_BITS-1:0], fits};
         cnt_in  = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      quot_ff <= quot_in;
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign quot      = quot_ff;

endmodule

`default_nettype wire

// ===== src/dda_line_rasterizer.sv =====
// DDA line rasterizer top level: request sequencer, accumulators, pixel output.
// Depends on dda_pkg and dda_divider.
//
//   Channel   Ports     Payload
//   request   req_*     tdata = x_start, y_start, x_end, y_end (low bits up)
//   pixel     rsp_*     tdata = pixel_x, pixel_y; tlast = last_pixel
//
// A line is accepted, then passes through the shared divider (x increment,
// then y; skipped for equal endpoints) and then yields step+1 pixels, one
// pixel per cycle. A stalled pixel output holds the walk. Reset is
// synchronous and leaves the block idle and ready; req_tready is low from
// acceptance to the last pixel.
`default_nettype none

module dda_line_rasterizer #(
   parameter  int COORD_BITS = dda_pkg::COORD_BITS_DEF,
   parameter  int FRAC_BITS  = dda_pkg::FRAC_BITS_DEF,
   localparam int REQ_W      = 8 * ((4 * COORD_BITS + 7) / 8),
   localparam int RSP_W      = 8 * ((2 * COORD_BITS + 7) / 8)
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_tvalid,
   output logic                  req_tready,
   // x_start, y_start, x_end, y_end
   input  wire logic [REQ_W-1:0] req_tdata,
   output logic                  rsp_tvalid,
   input  wire logic             rsp_tready,
   // pixel_x, pixel_y
   output logic      [RSP_W-1:0] rsp_tdata,
   output logic                  rsp_tlast
);
   import dda_pkg::*;

   localparam int C  = COORD_BITS;
   localparam int AW = COORD_BITS + FRAC_BITS;
   localparam int IW = FRAC_BITS + 2;

   typedef enum logic [1:0] {IDLE, DIV_X, DIV_Y, WALK} state_type;

   state_type             state_ff, state_in;
   logic signed [AW-1:0]  x_acc_ff, x_acc_in, y_acc_ff, y_acc_in;
   logic signed [IW-1:0]  x_inc_ff, x_inc_in, y_inc_ff, y_inc_in;
   logic        [C-1:0]   steps_ff, steps_in;
   logic        [C-1:0]   step_ff, step_in;
   logic        [C-1:0]   dy_mag_ff, dy_mag_in;
   logic                  x_neg_ff, x_neg_in, y_neg_ff, y_neg_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic        [C-1:0]   px_ff, px_in, py_ff, py_in;
   logic                  last_ff, last_in;

   logic signed [C-1:0]   xs, ys, xe, ye;
   logic signed [C:0]     dx, dy, dx_abs, dy_abs;
   logic        [C-1:0]   dx_mag, dy_mag, step_c;
   logic                  accept, load;
   logic                  div_start;
   logic        [C-1:0]   div_numer, div_denom;
   div_stat_type          div_stat;
   logic        [FRAC_BITS:0] div_quot;
   logic signed [IW-1:0]  inc_c;

   function automatic logic [C-1:0] trunc_coord(input logic signed [AW-1:0] a);
      logic adj;
      adj = a[AW-1] & (|a[FRAC_BITS-1:0]);
      return a[AW-1:FRAC_BITS] + {{(C-1){1'b0}}, adj};
   endfunction

   assign req_tready = (state_ff == IDLE);
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      xs     = req_tdata[C-1:0];
      ys     = req_tdata[2*C-1:C];
      xe     = req_tdata[3*C-1:2*C];
      ye     = req_tdata[4*C-1:3*C];
      dx     = {xe[C-1], xe} - {xs[C-1], xs};
      dy     = {ye[C-1], ye} - {ys[C-1], ys};
      dx_abs = dx[C] ? -dx : dx;
      dy_abs = dy[C] ? -dy : dy;
      dx_mag = dx_abs[C-1:0];
      dy_mag = dy_abs[C-1:0];
      step_c = (dx_mag >= dy_mag) ? dx_mag : dy_mag;
   end

   always_comb begin
      div_start = 1'b0;
      div_numer = dy_mag_ff;
      div_denom = step_ff;
      if (state_ff == IDLE) begin
         div_start = accept && (step_c != '0);
         div_numer = dx_mag;
         div_denom = step_c;
      end else if (state_ff == DIV_X) begin
         div_start = div_stat.done;
      end
   end

   dda_divider #(
      .COORD_BITS(COORD_BITS),
      .FRAC_BITS (FRAC_BITS)
   ) u_div (
      .clock(clock),
      .reset(reset),
      .start(div_start),
      .numer(div_numer),
      .denom(div_denom),
      .stat (div_stat),
      .quot (div_quot)
   );

   always_comb begin
      state_in     = state_ff;
      x_acc_in     = x_acc_ff;
      y_acc_in     = y_acc_ff;
      x_inc_in     = x_inc_ff;
      y_inc_in     = y_inc_ff;
      steps_in     = steps_ff;
      step_in      = step_ff;
      dy_mag_in    = dy_mag_ff;
      x_neg_in     = x_neg_ff;
      y_neg_in     = y_neg_ff;
      rsp_valid_in = rsp_valid_ff;
      px_in        = px_ff;
      py_in        = py_ff;
      last_in      = last_ff;
      load         = !rsp_valid_ff || rsp_tready;
      inc_c        = {1'b0, div_quot};

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         IDLE: begin
            if (accept) begin
               x_acc_in  = {xs, {FRAC_BITS{1'b0}}};
               y_acc_in  = {ys, {FRAC_BITS{1'b0}}};
               x_inc_in  = '0;
               y_inc_in  = '0;
               steps_in  = step_c;
               step_in   = step_c;
               dy_mag_in = dy_mag;
               x_neg_in  = dx[C];
               y_neg_in  = dy[C];
               state_in  = (step_c == '0) ? WALK : DIV_X;
            end
         end
         DIV_X: begin
            if (div_stat.done) begin
               x_inc_in = x_neg_ff ? -inc_c : inc_c;
               state_in = DIV_Y;
            end
         end
         DIV_Y: begin
            if (div_stat.done) begin
               y_inc_in = y_neg_ff ? -inc_c : inc_c;
               state_in = WALK;
            end
         end
         WALK: begin
            if (load) begin
               rsp_valid_in = 1'b1;
               px_in        = trunc_coord(x_acc_ff);
               py_in        = trunc_coord(y_acc_ff);
               last_in      = (steps_ff == '0);
               if (steps_ff == '0) begin
                  state_in = IDLE;
               end else begin
                  x_acc_in = x_acc_ff + {{(AW-IW){x_inc_ff[IW-1]}}, x_inc_ff};
                  y_acc_in = y_acc_ff + {{(AW-IW){y_inc_ff[IW-1]}}, y_inc_ff};
                  steps_in = steps_ff - 1'b1;
               end
            end
         end
         default: begin
            state_in = IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      x_acc_ff  <= x_acc_in;
      y_acc_ff  <= y_acc_in;
      x_inc_ff  <= x_inc_in;
      y_inc_ff  <= y_inc_in;
      step_ff   <= step_in;
      dy_mag_ff <= dy_mag_in;
      x_neg_ff  <= x_neg_in;
      y_neg_ff  <= y_neg_in;
      px_ff     <= px_in;
      py_ff     <= py_in;
      last_ff   <= last_in;
      if (reset) begin
         state_ff     <= IDLE;
         steps_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         steps_ff     <= steps_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      rsp_tdata          = '0;
      rsp_tdata[C-1:0]   = px_ff;
      rsp_tdata[2*C-1:C] = py_ff;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = last_ff;

endmodule

`default_nettype wire

// ===== src/dda_checker.sv =====
// Port-level checker for the DDA line rasterizer, bound to the top level.
// Depends on dda_line_rasterizer_macros.svh and dda_line_rasterizer.
`default_nettype none
`include "dda_line_rasterizer_macros.svh"

module dda_checker #(
   parameter int RSP_W = 16
) (
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             req_tvalid,
   input wire logic             req_tready,
   input wire logic             rsp_tvalid,
   input wire logic             rsp_tready,
   input wire logic [RSP_W-1:0] rsp_tdata,
   input wire logic             rsp_tlast
);

   logic req_acc;
   logic rsp_stall;

   assign req_acc   = req_tvalid && req_tready;
   assign rsp_stall = rsp_tvalid && !rsp_tready;

   `DDA_ASSERT_DIS(a_rsp_hold, clock, reset, rsp_stall |=> rsp_tvalid)
   `DDA_ASSERT_DIS(a_rsp_stable, clock, reset, rsp_stall |=> $stable(rsp_tdata) && $stable(rsp_tlast))
   `DDA_ASSERT_DIS(a_busy_after_accept, clock, reset, req_acc |=> !req_tready)
   `DDA_ASSERT_DIS(a_no_accept_mid_line, clock, reset, rsp_tvalid && !rsp_tlast |-> !req_tready)
   `DDA_ASSERT_ALL(a_reset_clears_output, clock, reset |=> !rsp_tvalid)

endmodule

bind dda_line_rasterizer dda_checker #(
   .RSP_W(RSP_W)
) u_dda_checker (
   .clock     (clock),
   .reset     (reset),
   .req_tvalid(req_tvalid),
   .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid),
   .rsp_tready(rsp_tready),
   .rsp_tdata (rsp_tdata),
   .rsp_tlast (rsp_tlast)
);

`default_nettype wire
